@@ rtl/smoc_pkg.sv @@
// Shared types and constants for the stream message order checker.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package smoc_pkg;

    // Table geometry
    localparam int STREAM_SLOTS   = 16;
    localparam int PACKET_ID_BITS = 16;
    localparam int SLOT_W         = (STREAM_SLOTS > 1) ? $clog2(STREAM_SLOTS) : 1;

    // Field widths of the stream interface
    localparam int IDX_W       = 4;
    localparam int PKT_IN_W    = 16;
    localparam int SEQ_W       = 64;
    localparam int IN_TUSER_W  = 4;
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 72;

    // Message kinds
    typedef enum logic [2:0] {
        KIND_EVENT        = 3'd0,
        KIND_STREAM_BEGIN = 3'd1,
        KIND_STREAM_END   = 3'd2,
        KIND_PACKET_BEGIN = 3'd3,
        KIND_PACKET_END   = 3'd4,
        KIND_UNATTACHED   = 3'd5
    } kind_t;

    // Result codes
    typedef enum logic [3:0] {
        ERR_OK           = 4'd0,
        ERR_NO_BEGIN     = 4'd1,
        ERR_FIRST_SEQ    = 4'd2,
        ERR_ENDED        = 4'd3,
        ERR_SEQ_MISMATCH = 4'd4,
        ERR_REPEAT_BEGIN = 4'd5,
        ERR_END_IN_PKT   = 4'd6,
        ERR_NESTED_PKT   = 4'd7,
        ERR_STRAY_PKT_END= 4'd8,
        ERR_WRONG_PKT    = 4'd9,
        ERR_NOT_ENDED    = 4'd10
    } err_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture the input request, clear the scan
        logic exec;       // check one message and update the table
        logic scan_step;  // examine one slot and advance the walk
        logic scan_done;  // post the end-check result
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic end_check;  // captured request is an end check
        logic scan_last;  // walk sits on the last slot
    } status_t;

endpackage

@@ rtl/smoc_ctrl.sv @@
// Controller state machine of the stream message order checker.
// Drives the stream handshakes and sequences the datapath; uses smoc_pkg.
`timescale 1ns / 1ps

module smoc_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  smoc_pkg::status_t status,
    output smoc_pkg::cmd_t   cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   out_valid_reg;

    // Decode next state and datapath commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && ready_reg)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (status.end_check)
                begin
                    cmd.scan_step = 1'b1;
                    if (status.scan_last)
                    begin
                        cmd.scan_done = 1'b1;
                        state_next    = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
                else
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    cmd.scan_done = 1'b1;
                    state_next    = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and the handshake outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ready_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ready_reg     <= (state_next == ST_IDLE);
            out_valid_reg <= (state_next == ST_OUT);
        end
    end

    assign s_tready = ready_reg;
    assign m_tvalid = out_valid_reg;

endmodule

@@ rtl/smoc_datapath.sv @@
// Datapath of the stream message order checker: request capture, per-stream
// table, message check, end-check slot walk and result register. Uses smoc_pkg.
`timescale 1ns / 1ps

module smoc_datapath
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  smoc_pkg::cmd_t               cmd,
    output smoc_pkg::status_t            status,
    input  logic                         in_req_type,
    input  logic [2:0]                   in_msg_kind,
    input  logic [smoc_pkg::IDX_W-1:0]   in_stream_index,
    input  logic [smoc_pkg::PKT_IN_W-1:0] in_packet_id,
    input  logic                         in_seq_present,
    input  logic [smoc_pkg::SEQ_W-1:0]   in_seq_value,
    output logic                         valid_res,
    output smoc_pkg::err_t               error_code,
    output logic [smoc_pkg::SEQ_W-1:0]   assigned_seq
);

    localparam logic [smoc_pkg::SLOT_W-1:0] SLOT_LAST =
        smoc_pkg::SLOT_W'(smoc_pkg::STREAM_SLOTS - 1);

    // Captured request
    logic                                req_type_reg;
    smoc_pkg::kind_t                     kind_reg;
    logic [smoc_pkg::IDX_W-1:0]          idx_reg;
    logic [smoc_pkg::PACKET_ID_BITS-1:0] pkt_reg;
    logic                                present_reg;
    logic [smoc_pkg::SEQ_W-1:0]          seq_reg;

    // Stream table
    logic [smoc_pkg::STREAM_SLOTS-1:0]   known_reg;
    logic [smoc_pkg::STREAM_SLOTS-1:0]   ended_reg;
    logic [smoc_pkg::STREAM_SLOTS-1:0]   open_reg;
    logic [smoc_pkg::PACKET_ID_BITS-1:0] open_pkt_reg [smoc_pkg::STREAM_SLOTS];
    logic [smoc_pkg::SEQ_W-1:0]          exp_seq_reg  [smoc_pkg::STREAM_SLOTS];

    // End-check walk
    logic [smoc_pkg::SLOT_W-1:0]         cnt_reg;
    logic                                found_reg;
    logic                                hit;

    // Result register
    logic                                res_valid_reg;
    smoc_pkg::err_t                      res_err_reg;
    logic [smoc_pkg::SEQ_W-1:0]          res_seq_reg;

    // Message check outcome
    logic [smoc_pkg::SLOT_W-1:0]         slot;
    logic                                in_range;
    logic                                cur_known;
    logic                                cur_ended;
    logic                                cur_open;
    logic [smoc_pkg::PACKET_ID_BITS-1:0] cur_pkt;
    logic [smoc_pkg::SEQ_W-1:0]          cur_exp;
    logic [smoc_pkg::SEQ_W-1:0]          given;
    logic [smoc_pkg::SEQ_W-1:0]          filled;
    logic                                chk_ok;
    smoc_pkg::err_t                      chk_err;
    logic [smoc_pkg::SEQ_W-1:0]          chk_seq;
    logic                                wr_en;
    logic                                nxt_known;
    logic                                nxt_ended;
    logic                                nxt_open;
    logic                                wr_pkt;
    logic [smoc_pkg::SEQ_W-1:0]          nxt_exp;

    // Capture the request
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_type_reg <= in_req_type;
            kind_reg     <= smoc_pkg::kind_t'(in_msg_kind);
            idx_reg      <= in_stream_index;
            pkt_reg      <= smoc_pkg::PACKET_ID_BITS'(in_packet_id);
            present_reg  <= in_seq_present;
            seq_reg      <= in_seq_value;
        end
    end

    // Read the addressed entry
    assign slot      = smoc_pkg::SLOT_W'(idx_reg);
    assign in_range  = (32'(idx_reg) < smoc_pkg::STREAM_SLOTS);
    assign cur_known = known_reg[slot];
    assign cur_ended = ended_reg[slot];
    assign cur_open  = open_reg[slot];
    assign cur_pkt   = open_pkt_reg[slot];
    assign cur_exp   = exp_seq_reg[slot];
    assign given     = present_reg ? seq_reg : '0;
    assign filled    = present_reg ? seq_reg : cur_exp;

    // Check one message against its stream entry
    always_comb
    begin
        chk_ok    = 1'b0;
        chk_err   = smoc_pkg::ERR_OK;
        chk_seq   = given;
        wr_en     = 1'b0;
        nxt_known = cur_known;
        nxt_ended = cur_ended;
        nxt_open  = cur_open;
        wr_pkt    = 1'b0;
        nxt_exp   = cur_exp + 64'd1;
        if (kind_reg > smoc_pkg::KIND_PACKET_END || !in_range)
        begin
            chk_ok = 1'b1;
        end
        else if (!cur_known)
        begin
            if (kind_reg != smoc_pkg::KIND_STREAM_BEGIN)
            begin
                chk_err = smoc_pkg::ERR_NO_BEGIN;
            end
            else if (present_reg && seq_reg != '0)
            begin
                chk_err = smoc_pkg::ERR_FIRST_SEQ;
            end
            else
            begin
                chk_ok    = 1'b1;
                chk_seq   = '0;
                wr_en     = 1'b1;
                nxt_known = 1'b1;
                nxt_ended = 1'b0;
                nxt_open  = 1'b0;
                nxt_exp   = 64'd1;
            end
        end
        else if (cur_ended)
        begin
            chk_err = smoc_pkg::ERR_ENDED;
        end
        else if (present_reg && seq_reg != cur_exp)
        begin
            chk_err = smoc_pkg::ERR_SEQ_MISMATCH;
        end
        else
        begin
            chk_seq = filled;
            case (kind_reg)
                smoc_pkg::KIND_STREAM_BEGIN:
                begin
                    chk_err = smoc_pkg::ERR_REPEAT_BEGIN;
                end
                smoc_pkg::KIND_STREAM_END:
                begin
                    if (cur_open)
                    begin
                        chk_err = smoc_pkg::ERR_END_IN_PKT;
                    end
                    else
                    begin
                        nxt_ended = 1'b1;
                        wr_en     = 1'b1;
                    end
                end
                smoc_pkg::KIND_PACKET_BEGIN:
                begin
                    if (cur_open)
                    begin
                        chk_err = smoc_pkg::ERR_NESTED_PKT;
                    end
                    else
                    begin
                        nxt_open = 1'b1;
                        wr_pkt   = 1'b1;
                        wr_en    = 1'b1;
                    end
                end
                smoc_pkg::KIND_PACKET_END:
                begin
                    if (!cur_open)
                    begin
                        chk_err = smoc_pkg::ERR_STRAY_PKT_END;
                    end
                    else
                    begin
                        nxt_open = 1'b0;
                        wr_en    = 1'b1;
                    end
                end
                default:
                begin
                    if (!cur_open || cur_pkt != pkt_reg)
                    begin
                        chk_err = smoc_pkg::ERR_WRONG_PKT;
                    end
                    else
                    begin
                        wr_en = 1'b1;
                    end
                end
            endcase
            chk_ok = wr_en;
        end
    end

    // Update the stream flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            known_reg <= '0;
            ended_reg <= '0;
            open_reg  <= '0;
        end
        else if (cmd.exec && wr_en)
        begin
            known_reg[slot] <= nxt_known;
            ended_reg[slot] <= nxt_ended;
            open_reg[slot]  <= nxt_open;
        end
    end

    // Update the packet id and the expected sequence number
    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
        begin
            exp_seq_reg[slot] <= nxt_exp;
            if (wr_pkt)
            begin
                open_pkt_reg[slot] <= pkt_reg;
            end
        end
    end

    // Walk the slots for an end check
    assign hit = known_reg[cnt_reg] && !ended_reg[cnt_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            found_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            cnt_reg   <= '0;
            found_reg <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            cnt_reg   <= cnt_reg + 1'b1;
            found_reg <= found_reg | hit;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            res_valid_reg <= chk_ok;
            res_err_reg   <= chk_err;
            res_seq_reg   <= chk_seq;
        end
        else if (cmd.scan_done)
        begin
            res_valid_reg <= !(found_reg | hit);
            res_err_reg   <= (found_reg | hit) ? smoc_pkg::ERR_NOT_ENDED : smoc_pkg::ERR_OK;
            res_seq_reg   <= '0;
        end
    end

    assign status.end_check = req_type_reg;
    assign status.scan_last = (cnt_reg == SLOT_LAST);

    assign valid_res    = res_valid_reg;
    assign error_code   = res_err_reg;
    assign assigned_seq = res_seq_reg;

endmodule

@@ rtl/stream_message_order_checker.sv @@
// A request is captured on acceptance. A message check registers its result in
// the execute state; an end check walks the table through the execute and scan
// states, one table slot per cycle. The result is held in the output state until
// the sink takes it, and the block takes one request at a time. Asynchronous
// active-low reset clears all stream flags at once, so the block takes requests
// right after reset with no clearing pass.
`timescale 1ns / 1ps

module stream_message_order_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tdata: stream_index[3:0], packet_id[19:4], seq_present[20], seq_value[84:21]
    input  logic [smoc_pkg::IN_TDATA_W-1:0]     s_tdata,
    // tuser: req_type[0], msg_kind[3:1]
    input  logic [smoc_pkg::IN_TUSER_W-1:0]     s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tdata: error_code[3:0], assigned_seq[67:4]
    output logic [smoc_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // tuser: valid_res
    output logic                                m_tuser
);

    smoc_pkg::cmd_t              cmd;
    smoc_pkg::status_t           status;
    smoc_pkg::err_t              error_code;
    logic [smoc_pkg::SEQ_W-1:0]  assigned_seq;

    smoc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    smoc_datapath u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .in_req_type     (s_tuser[0]),
        .in_msg_kind     (s_tuser[3:1]),
        .in_stream_index (s_tdata[3:0]),
        .in_packet_id    (s_tdata[19:4]),
        .in_seq_present  (s_tdata[20]),
        .in_seq_value    (s_tdata[84:21]),
        .valid_res       (m_tuser),
        .error_code      (error_code),
        .assigned_seq    (assigned_seq)
    );

    // Pack the result
    assign m_tdata = {4'b0000, assigned_seq, error_code};

endmodule

@@ rtl/smoc_checker.sv @@
// Port-level assertions for the stream message order checker, bound to the
// top level. Depends on the top-level port list only.
`timescale 1ns / 1ps

module smoc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [87:0] s_tdata,
    input logic [3:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic        m_tuser
);

    // Take no request while a result is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("request accepted while a result is pending");

    // Drop ready right after a request is taken
    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready held after accepting a request");

    // Flag and code agree
    a_flag_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == (m_tdata[3:0] == 4'd0)))
        else $error("valid flag disagrees with error code");

    // Code stays within the defined set
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[3:0] <= 4'd10))
        else $error("error code out of range");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind stream_message_order_checker smoc_checker u_smoc_checker (.*);

@@ tb/stream_message_order_checker_test.sv @@
// Self-checking testbench for stream_message_order_checker: directed ordering cases, then
// random stream traffic with idle and stall bursts, checked against an in-bench model.
// Depends on rtl/smoc_pkg.sv and rtl/stream_message_order_checker.sv.
`timescale 1ns / 1ps

module stream_message_order_checker_test;

    import smoc_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 1200;
    localparam int CALM_TAIL     = 150;
    localparam int SETTLE_CYCLES = STREAM_SLOTS + 8;
    localparam int MAX_PRINTED   = 40;

    // Kind codes beyond the named ones; the block treats them as unattached
    localparam bit [2:0] KIND_SPARE_6 = 3'd6;
    localparam bit [2:0] KIND_SPARE_7 = 3'd7;

    localparam bit [63:0] SEQ_ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        bit                       end_check;
        bit [2:0]                 kind;
        bit [IDX_W-1:0]           slot;
        bit [PKT_IN_W-1:0]        pkt;
        bit                       seq_present;
        bit [SEQ_W-1:0]           seq;
    } request_t;

    typedef struct packed {
        bit                       known;
        bit                       ended;
        bit                       pkt_open;
        bit [PACKET_ID_BITS-1:0]  open_id;
        bit [SEQ_W-1:0]           next_seq;
    } slot_state_t;

    typedef slot_state_t [STREAM_SLOTS-1:0] stream_table_t;

    typedef struct packed {
        logic                     ok;
        err_t                     code;
        logic [SEQ_W-1:0]         seq;
    } verdict_t;

    typedef struct packed {
        stream_table_t            tbl;
        verdict_t                 res;
    } step_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata = '0;
    logic [IN_TUSER_W-1:0]   s_tuser = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    m_tuser;

    request_t       pending_messages[$];
    verdict_t       expected_verdicts[$];
    stream_table_t  plan_table = '0;
    stream_table_t  live_table = '0;
    request_t       in_flight;
    verdict_t       got_verdict;
    step_t          live_step;
    int             fail_count = 0;
    int             accepted_count = 0;
    int             result_count = 0;
    int             cycle_count = 0;
    int             send_gap = 0;
    int             sink_stall = 0;

    stream_message_order_checker uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Work out the verdict for one request and the table that follows it
    function automatic step_t predict_verdict(input request_t r, input stream_table_t tbl);
        step_t        o;
        slot_state_t  st;
        bit [63:0]    given;
        int           i;
        o.tbl = tbl;
        o.res.ok = 1'b1;
        o.res.code = ERR_OK;
        o.res.seq = '0;
        given = r.seq_present ? r.seq : 64'd0;
        if (r.end_check)
        begin
            for (i = 0; i < STREAM_SLOTS; i++)
                if (tbl[i].known && !tbl[i].ended)
                    o.res.code = ERR_NOT_ENDED;
            o.res.ok = (o.res.code == ERR_OK);
            return o;
        end
        o.res.seq = given;
        if (r.kind > KIND_PACKET_END || r.slot >= STREAM_SLOTS)
            return o;
        st = tbl[r.slot];
        if (!st.known)
        begin
            if (r.kind != KIND_STREAM_BEGIN)
                o.res.code = ERR_NO_BEGIN;
            else if (r.seq_present && r.seq != 64'd0)
                o.res.code = ERR_FIRST_SEQ;
            else
            begin
                st.known = 1'b1;
                st.ended = 1'b0;
                st.pkt_open = 1'b0;
                st.next_seq = 64'd1;
            end
        end
        else if (st.ended)
            o.res.code = ERR_ENDED;
        else
        begin
            o.res.seq = r.seq_present ? r.seq : st.next_seq;
            if (r.seq_present && r.seq != st.next_seq)
                o.res.code = ERR_SEQ_MISMATCH;
            else
            begin
                case (r.kind)
                    KIND_STREAM_BEGIN:
                        o.res.code = ERR_REPEAT_BEGIN;
                    KIND_STREAM_END:
                        if (st.pkt_open)
                            o.res.code = ERR_END_IN_PKT;
                        else
                            st.ended = 1'b1;
                    KIND_PACKET_BEGIN:
                        if (st.pkt_open)
                            o.res.code = ERR_NESTED_PKT;
                        else
                        begin
                            st.pkt_open = 1'b1;
                            st.open_id = r.pkt[PACKET_ID_BITS-1:0];
                        end
                    KIND_PACKET_END:
                        if (!st.pkt_open)
                            o.res.code = ERR_STRAY_PKT_END;
                        else
                            st.pkt_open = 1'b0;
                    default:
                        if (!st.pkt_open || st.open_id != r.pkt[PACKET_ID_BITS-1:0])
                            o.res.code = ERR_WRONG_PKT;
                endcase
            end
            if (o.res.code == ERR_OK)
                st.next_seq = st.next_seq + 64'd1;
        end
        o.res.ok = (o.res.code == ERR_OK);
        if (o.res.ok)
            o.tbl[r.slot] = st;
        return o;
    endfunction

    function automatic request_t make_msg(input bit [2:0] kind, input int slot,
                                          input bit [15:0] pkt, input bit present,
                                          input bit [63:0] seq);
        request_t r;
        r.end_check = 1'b0;
        r.kind = kind;
        r.slot = IDX_W'(slot);
        r.pkt = pkt;
        r.seq_present = present;
        r.seq = seq;
        return r;
    endfunction

    // Build one random request, mostly well-formed for the planned table state
    function automatic request_t plan_request(input bit closing, input stream_table_t tbl);
        request_t     r;
        slot_state_t  st;
        int           roll;
        int           tries;
        r.end_check = 1'b0;
        r.kind = 3'($urandom_range(0, 7));
        r.slot = IDX_W'($urandom_range(0, STREAM_SLOTS - 1));
        r.pkt = PKT_IN_W'($urandom);
        r.seq_present = 1'($urandom_range(0, 1));
        r.seq = {$urandom, $urandom};
        roll = $urandom_range(0, 99);
        if (roll < 3)
        begin
            r.end_check = 1'b1;
            return r;
        end
        if (roll < 10)
            return r;
        // Prefer a stream that is still live
        for (tries = 0; tries < 4 && tbl[r.slot].ended; tries++)
            r.slot = IDX_W'($urandom_range(0, STREAM_SLOTS - 1));
        st = tbl[r.slot];
        roll = $urandom_range(0, 99);
        if (!st.known)
        begin
            r.kind = KIND_STREAM_BEGIN;
            r.seq = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : 64'd0;
            return r;
        end
        if (st.ended)
        begin
            r.kind = 3'($urandom_range(0, 4));
            return r;
        end
        if (st.pkt_open)
        begin
            if (roll < (closing ? 50 : 20))
                r.kind = KIND_PACKET_END;
            else if (roll < 88)
            begin
                r.kind = KIND_EVENT;
                r.pkt = st.open_id;
            end
            else if (roll < 92)
                r.kind = KIND_PACKET_BEGIN;
            else if (roll < 95)
                r.kind = KIND_STREAM_END;
            else if (roll < 98)
            begin
                r.kind = KIND_EVENT;
                r.pkt = st.open_id ^ (16'd1 << $urandom_range(0, 15));
            end
            else
                r.kind = KIND_STREAM_BEGIN;
        end
        else
        begin
            if (roll < (closing ? 40 : 1))
                r.kind = KIND_STREAM_END;
            else if (roll < 80)
            begin
                r.kind = KIND_PACKET_BEGIN;
                if ($urandom_range(0, 9) == 0)
                    r.pkt = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            end
            else if (roll < 87)
                r.kind = KIND_EVENT;
            else if (roll < 93)
                r.kind = KIND_PACKET_END;
            else if (roll < 96)
                r.kind = KIND_STREAM_BEGIN;
            else
                r.kind = KIND_UNATTACHED;
        end
        // Carry the expected number, now and then a wrong one
        roll = $urandom_range(0, 19);
        if (roll == 0)
            r.seq = st.next_seq + 64'($urandom_range(1, 3));
        else if (roll != 1)
            r.seq = st.next_seq;
        return r;
    endfunction

    task automatic queue_request(input request_t r);
        step_t s;
        s = predict_verdict(r, plan_table);
        plan_table = s.tbl;
        pending_messages.push_back(r);
    endtask

    task automatic report_mismatch(input string what);
        if (fail_count < MAX_PRINTED)
            $display("MISMATCH at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    function automatic bit idling_allowed();
        return pending_messages.size() >= CALM_TAIL && ((accepted_count / 200) % 3) != 1;
    endfunction

    // Driver: present pending requests, predict each one as it is taken
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                live_step = predict_verdict(in_flight, live_table);
                live_table = live_step.tbl;
                expected_verdicts.push_back(live_step.res);
                accepted_count++;
                if (idling_allowed() && $urandom_range(0, 3) == 0)
                    send_gap = $urandom_range(1, 7);
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_messages.size() > 0)
                begin
                    in_flight = pending_messages.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {3'b000, in_flight.seq, in_flight.seq_present,
                                in_flight.pkt, in_flight.slot};
                    s_tuser <= {in_flight.kind, in_flight.end_check};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result with the oldest expectation, stall the sink
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_verdicts.size() == 0)
                    report_mismatch("result arrived with nothing expected");
                else
                begin
                    got_verdict = expected_verdicts.pop_front();
                    if (m_tuser !== got_verdict.ok)
                        report_mismatch($sformatf("result %0d: valid_res %b, expected %b",
                                                  result_count, m_tuser, got_verdict.ok));
                    if (m_tdata[3:0] !== got_verdict.code)
                        report_mismatch($sformatf("result %0d: error_code %0d, expected %0d",
                                                  result_count, m_tdata[3:0],
                                                  got_verdict.code));
                    if (m_tdata[67:4] !== got_verdict.seq)
                        report_mismatch($sformatf("result %0d: assigned_seq %h, expected %h",
                                                  result_count, m_tdata[67:4],
                                                  got_verdict.seq));
                end
                result_count++;
            end
            if (sink_stall > 0)
            begin
                sink_stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (idling_allowed() && $urandom_range(0, 4) == 0)
                    sink_stall = $urandom_range(1, 7);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        request_t  r;
        int        k;
        int        drain;

        // Directed: unknown stream, first number, nesting, wrong packet, ended stream
        r = '0;
        r.end_check = 1'b1;
        queue_request(r);
        queue_request(make_msg(KIND_EVENT, 0, 16'h0000, 1'b0, 64'd0));
        queue_request(make_msg(KIND_PACKET_END, 0, 16'h1234, 1'b1, SEQ_ALL_ONES));
        queue_request(make_msg(KIND_STREAM_BEGIN, 0, 16'h0000, 1'b1, 64'd5));
        queue_request(make_msg(KIND_STREAM_BEGIN, 0, 16'h0000, 1'b1, 64'd0));
        queue_request(r);
        queue_request(make_msg(KIND_STREAM_BEGIN, 0, 16'h0000, 1'b0, 64'd0));
        queue_request(make_msg(KIND_EVENT, 0, 16'h0000, 1'b0, 64'd0));
        queue_request(make_msg(KIND_PACKET_END, 0, 16'h0000, 1'b0, 64'd0));
        queue_request(make_msg(KIND_PACKET_BEGIN, 0, 16'hFFFF, 1'b1, 64'd1));
        queue_request(make_msg(KIND_PACKET_BEGIN, 0, 16'h0000, 1'b0, 64'd0));
        queue_request(make_msg(KIND_EVENT, 0, 16'h0000, 1'b0, 64'd0));
        queue_request(make_msg(KIND_EVENT, 0, 16'hFFFF, 1'b1, SEQ_ALL_ONES));
        queue_request(make_msg(KIND_EVENT, 0, 16'hFFFF, 1'b1, 64'd2));
        queue_request(make_msg(KIND_STREAM_END, 0, 16'h0000, 1'b0, 64'd0));
        queue_request(make_msg(KIND_PACKET_END, 0, 16'h0000, 1'b0, 64'd0));
        queue_request(make_msg(KIND_STREAM_END, 0, 16'h0000, 1'b1, 64'd4));
        queue_request(make_msg(KIND_EVENT, 0, 16'hFFFF, 1'b1, 64'd0));
        queue_request(make_msg(KIND_STREAM_BEGIN, 0, 16'h0000, 1'b0, 64'd0));
        queue_request(r);
        queue_request(make_msg(KIND_UNATTACHED, 3, 16'hFFFF, 1'b1, SEQ_ALL_ONES));
        queue_request(make_msg(KIND_SPARE_7, 9, 16'h0000, 1'b0, SEQ_ALL_ONES));
        queue_request(make_msg(KIND_SPARE_6, 15, 16'h5A5A, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA));
        queue_request(make_msg(KIND_STREAM_BEGIN, 15, 16'h0000, 1'b0, SEQ_ALL_ONES));
        queue_request(r);

        // Random traffic; the tail closes packets and ends streams
        for (k = 0; k < RANDOM_ITEMS; k++)
            queue_request(plan_request(k >= RANDOM_ITEMS - 250, plan_table));
        queue_request(r);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every request to be taken, then for the results to drain
        while (pending_messages.size() != 0 || s_tvalid)
            @(posedge clk);
        drain = 0;
        while (expected_verdicts.size() != 0 && drain < 4000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_verdicts.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_verdicts.size()));

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ stream_message_order_checker.f @@
rtl/smoc_pkg.sv
rtl/smoc_ctrl.sv
rtl/smoc_datapath.sv
rtl/stream_message_order_checker.sv
rtl/smoc_checker.sv
tb/stream_message_order_checker_test.sv
